### rtl/bdq_pkg.sv
package bdq_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int KIND_W   = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic [IDX_W:0] DEPTH_X  = (IDX_W + 1)'(DEPTH);
   localparam idx_type        LAST_IDX = IDX_W'(DEPTH - 1);
   localparam cnt_type        FULL_CNT = CNT_W'(DEPTH);

   // Request kinds.
   localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] K_REMOVE     = 3'd4;
   localparam logic [KIND_W-1:0] K_LIST       = 3'd5;
   localparam logic [KIND_W-1:0] K_CLEAR      = 3'd6;
   localparam logic [KIND_W-1:0] K_NONE       = 3'd7;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value_res;
      cnt_type                  count;
      logic                     last;
   } rsp_item_type;

   // Physical slot of logical position pos counted from base; pos is below DEPTH.
   function automatic idx_type slot_of(input idx_type base, input cnt_type pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, pos[IDX_W-1:0]};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

### rtl/bdq_ifs.sv
interface bdq_req_if;
   import bdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bdq_rsp_if;
   import bdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] value_res;
   logic [CNT_W-1:0]         count;
   logic                     last;

   modport source (output valid, output status, output value_res, output count,
                   output last, input ready);
   modport sink   (input valid, input status, input value_res, input count,
                   input last, output ready);
endinterface

### rtl/bdq_ram.sv
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bdq_outreg.sv
module bdq_outreg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bdq_pkg::rsp_item_type item,
   output logic                  free,
   bdq_rsp_if.source             rsp_ch
);
   import bdq_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.status    = item_ff.status;
   assign rsp_ch.value_res = item_ff.value_res;
   assign rsp_ch.count     = item_ff.count;
   assign rsp_ch.last      = item_ff.last;

endmodule

### rtl/bdq_seq.sv
module bdq_seq (
   input  logic                       clock,
   input  logic                       reset,
   bdq_req_if.sink                    req_ch,
   output logic                       wr_en,
   output bdq_pkg::idx_type           wr_addr,
   output logic [bdq_pkg::DATA_W-1:0] wr_data,
   output logic                       rd_en,
   output bdq_pkg::idx_type           rd_addr,
   input  logic [bdq_pkg::DATA_W-1:0] rd_data,
   input  logic                       out_free,
   output logic                       out_load,
   output bdq_pkg::rsp_item_type      out_item
);
   import bdq_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_POP      = 4'd2;
   localparam logic [3:0] S_LIST_RD  = 4'd3;
   localparam logic [3:0] S_LIST_EM  = 4'd4;
   localparam logic [3:0] S_SRCH_RD  = 4'd5;
   localparam logic [3:0] S_SRCH_CMP = 4'd6;
   localparam logic [3:0] S_SHIFT_RD = 4'd7;
   localparam logic [3:0] S_SHIFT_WR = 4'd8;
   localparam logic [3:0] S_EMIT     = 4'd9;

   logic [3:0]               state_ff, state_in;
   idx_type                  front_ff, front_in;
   cnt_type                  count_ff, count_in;
   cnt_type                  pos_ff, pos_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   rsp_item_type             res_ff, res_in;

   logic    is_full, is_empty;
   cnt_type pos_next;
   idx_type front_dec, front_inc;

   assign is_full   = (count_ff == FULL_CNT);
   assign is_empty  = (count_ff == '0);
   assign pos_next  = pos_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = value_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      out_load = 1'b0;
      out_item = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in  = req_ch.kind;
               value_in = req_ch.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_EMIT;
            case (kind_ff)
               K_PUSH_FRONT, K_PUSH_BACK: begin
                  if (is_full) begin
                     res_in = '{status: ST_FULL, value_res: '0, count: count_ff, last: 1'b1};
                  end else begin
                     wr_en = 1'b1;
                     if (kind_ff == K_PUSH_FRONT) begin
                        wr_addr  = front_dec;
                        front_in = front_dec;
                     end else begin
                        wr_addr = slot_of(front_ff, count_ff);
                     end
                     count_in = count_ff + 1'b1;
                     res_in   = '{status: ST_OK, value_res: value_ff,
                                  count: count_ff + 1'b1, last: 1'b1};
                  end
               end
               K_POP_FRONT, K_POP_BACK: begin
                  if (is_empty) begin
                     res_in = '{status: ST_EMPTY, value_res: '0, count: '0, last: 1'b1};
                  end else begin
                     rd_en = 1'b1;
                     if (kind_ff == K_POP_FRONT) begin
                        rd_addr  = front_ff;
                        front_in = front_inc;
                     end else begin
                        rd_addr = slot_of(front_ff, count_ff - 1'b1);
                     end
                     count_in = count_ff - 1'b1;
                     state_in = S_POP;
                  end
               end
               K_REMOVE, K_LIST: begin
                  if (is_empty) begin
                     res_in = '{status: ST_EMPTY, value_res: '0, count: '0, last: 1'b1};
                  end else begin
                     pos_in   = '0;
                     state_in = (kind_ff == K_REMOVE) ? S_SRCH_RD : S_LIST_RD;
                  end
               end
               K_CLEAR: begin
                  front_in = '0;
                  count_in = '0;
                  res_in   = '{status: ST_OK, value_res: '0, count: '0, last: 1'b1};
               end
               default: begin
                  // No request: nothing changes and no item goes out.
                  state_in = S_IDLE;
               end
            endcase
         end
         S_POP: begin
            // The read data register holds until the next read, so a stall is safe.
            out_item = '{status: ST_OK, value_res: $signed(rd_data), count: count_ff,
                         last: 1'b1};
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LIST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(front_ff, pos_ff);
            state_in = S_LIST_EM;
         end
         S_LIST_EM: begin
            out_item = '{status: ST_OK, value_res: $signed(rd_data), count: count_ff,
                         last: (pos_next == count_ff)};
            if (out_free) begin
               out_load = 1'b1;
               pos_in   = pos_next;
               state_in = (pos_next == count_ff) ? S_IDLE : S_LIST_RD;
            end
         end
         S_SRCH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(front_ff, pos_ff);
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if ($signed(rd_data) == value_ff) begin
               state_in = S_SHIFT_RD;
            end else if (pos_next == count_ff) begin
               res_in   = '{status: ST_NOT_FOUND, value_res: '0, count: count_ff,
                            last: 1'b1};
               state_in = S_EMIT;
            end else begin
               pos_in   = pos_next;
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            // Close the gap: each later entry moves one place toward the front.
            if (pos_next < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = slot_of(front_ff, pos_next);
               state_in = S_SHIFT_WR;
            end else begin
               count_in = count_ff - 1'b1;
               res_in   = '{status: ST_OK, value_res: value_ff, count: count_ff - 1'b1,
                            last: 1'b1};
               state_in = S_EMIT;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(front_ff, pos_ff);
            wr_data  = rd_data;
            pos_in   = pos_next;
            state_in = S_SHIFT_RD;
         end
         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
      res_ff   <= res_in;
   end

endmodule

### rtl/bounded_deque_with_delete.sv
// Channel   Role    Handshake      Payload
// req_ch    in      valid/ready    kind, value
// rsp_ch    out     valid/ready    status, value_res, count, last
//
// One request is handled at a time; req_ch.ready is high only while idle.
// A listing reads and emits each entry in turn; a removal reads and compares
// each entry from the front until a match, then moves each later entry one place
// toward the front; all reads go through the single read port, whose read data
// is registered.
// Reset empties the deque at once; the entry memory is not cleared. A stalled
// rsp_ch holds the sequencer at its next result while one waits in the output register.
module bounded_deque_with_delete (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_ch,
   bdq_rsp_if.source rsp_ch
);
   import bdq_pkg::*;

   logic              wr_en, rd_en;
   idx_type           wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;
   logic              out_free, out_load;
   rsp_item_type      out_item;

   bdq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .out_free (out_free),
      .out_load (out_load),
      .out_item (out_item)
   );

   bdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bdq_outreg u_outreg (
      .clock  (clock),
      .reset  (reset),
      .load   (out_load),
      .item   (out_item),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

endmodule

### rtl/bdq_chk.sv
module bdq_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bdq_pkg::STATUS_W-1:0] rsp_status,
   input logic [bdq_pkg::CNT_W-1:0]    rsp_count,
   input logic                         rsp_last
);
   import bdq_pkg::*;

   // A pending result must not be dropped while the sink stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped under stall");

   // Requests are taken one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in work");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= FULL_CNT)
      else $error("count above capacity");

   // Only a listing gives more than one result, and those are all successful.
   a_multi_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_OK)
      else $error("non-final result with failing status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == FULL_CNT)
      else $error("full status while not at capacity");

endmodule

bind bounded_deque_with_delete bdq_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_count  (rsp_ch.count),
   .rsp_last   (rsp_ch.last)
);

### sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdq_pkg::*;

   localparam int TAIL_CYCLES = 120;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdq_req_if req_ch ();
   bdq_rsp_if rsp_ch ();

   bounded_deque_with_delete dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the deque, updated as each item is accepted.
   logic signed [DATA_W-1:0] dq_store [DEPTH];
   int dq_front = 0;
   int dq_count = 0;

   rsp_item_type pending_rsp [$];

   int error_count     = 0;
   int results_checked = 0;
   int full_rejects    = 0;
   int not_found_hits  = 0;
   int kind_hits [8];

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_cycles = 0;

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic int ring_slot(input int pos);
      return (dq_front + pos) % DEPTH;
   endfunction

   function automatic void queue_result(input logic [STATUS_W-1:0] status,
                                        input logic signed [DATA_W-1:0] value,
                                        input logic last);
      rsp_item_type r;
      r.status    = status;
      r.value_res = value;
      r.count     = cnt_type'(dq_count);
      r.last      = last;
      pending_rsp.push_back(r);
   endfunction

   function automatic void deque_predict(input logic [KIND_W-1:0] kind,
                                         input logic signed [DATA_W-1:0] value);
      logic signed [DATA_W-1:0] popped;
      int hit;
      kind_hits[kind]++;
      case (kind)
         K_PUSH_FRONT, K_PUSH_BACK: begin
            if (dq_count == DEPTH) begin
               full_rejects++;
               queue_result(ST_FULL, '0, 1'b1);
            end else begin
               if (kind == K_PUSH_FRONT) begin
                  dq_front = (dq_front + DEPTH - 1) % DEPTH;
                  dq_store[dq_front] = value;
               end else begin
                  dq_store[ring_slot(dq_count)] = value;
               end
               dq_count++;
               queue_result(ST_OK, value, 1'b1);
            end
         end
         K_POP_FRONT, K_POP_BACK: begin
            if (dq_count == 0) begin
               queue_result(ST_EMPTY, '0, 1'b1);
            end else begin
               if (kind == K_POP_FRONT) begin
                  popped   = dq_store[dq_front];
                  dq_front = (dq_front + 1) % DEPTH;
               end else begin
                  popped = dq_store[ring_slot(dq_count - 1)];
               end
               dq_count--;
               queue_result(ST_OK, popped, 1'b1);
            end
         end
         K_REMOVE: begin
            hit = -1;
            for (int i = dq_count - 1; i >= 0; i--) begin
               if (dq_store[ring_slot(i)] == value) hit = i;
            end
            if (dq_count == 0) begin
               queue_result(ST_EMPTY, '0, 1'b1);
            end else if (hit < 0) begin
               not_found_hits++;
               queue_result(ST_NOT_FOUND, '0, 1'b1);
            end else begin
               // Later entries close the gap so that order is kept.
               for (int j = hit; j + 1 < dq_count; j++) begin
                  dq_store[ring_slot(j)] = dq_store[ring_slot(j + 1)];
               end
               dq_count--;
               queue_result(ST_OK, value, 1'b1);
            end
         end
         K_LIST: begin
            if (dq_count == 0) begin
               queue_result(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < dq_count; i++) begin
                  queue_result(ST_OK, dq_store[ring_slot(i)], i == dq_count - 1);
               end
            end
         end
         K_CLEAR: begin
            dq_count = 0;
            dq_front = 0;
            queue_result(ST_OK, '0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 7)) - 4;
         4:          return 32'sh7fffffff;
         5:          return 32'sh80000000;
         default:    return $urandom;
      endcase
   endfunction

   // Offers one item and returns right after the edge at which it was taken.
   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic signed [DATA_W-1:0] value);
      int gap;
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_ch.valid <= 1'b0;
         req_ch.kind  <= KIND_W'($urandom);
         req_ch.value <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.value <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      deque_predict(kind, value);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
   endtask

   task automatic run_random(input int n, input int push_weight);
      int sent;
      int roll;
      logic [KIND_W-1:0] kind;
      logic signed [DATA_W-1:0] value;
      sent = 0;
      while (sent < n) begin
         roll  = $urandom_range(0, 99);
         value = pick_value();
         if (roll < push_weight) begin
            kind = $urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT;
         end else if (roll < 70) begin
            kind = $urandom_range(0, 1) ? K_POP_BACK : K_POP_FRONT;
         end else if (roll < 85) begin
            kind = K_REMOVE;
            // Mostly search for a value that is really held, so removes succeed.
            if (dq_count > 0 && $urandom_range(0, 3) != 0) begin
               value = dq_store[ring_slot($urandom_range(0, dq_count - 1))];
            end
         end else if (roll < 93) begin
            kind = K_LIST;
         end else if (roll < 96) begin
            kind = K_CLEAR;
         end else begin
            kind = K_NONE;
         end
         send_item(kind, value);
         if (kind != K_NONE) sent++;
      end
   endtask

   task automatic test_basic_ops();
      send_item(K_PUSH_BACK, 32'sh7fffffff);
      send_item(K_PUSH_FRONT, 32'sh80000000);
      send_item(K_PUSH_BACK, 7);
      send_item(K_PUSH_FRONT, 7);
      send_item(K_PUSH_BACK, -1);
      send_item(K_LIST, '0);
      // Duplicate value: only the one nearest the front goes.
      send_item(K_REMOVE, 7);
      send_item(K_REMOVE, 12345);
      send_item(K_POP_FRONT, '0);
      send_item(K_POP_BACK, '0);
      send_item(K_REMOVE, 7);
      send_item(K_POP_BACK, '0);
      send_item(K_POP_FRONT, '0);
      send_item(K_POP_BACK, '0);
      send_item(K_REMOVE, 0);
      send_item(K_LIST, '0);
      send_item(K_NONE, 32'sh5a5a5a5a);
      send_item(K_PUSH_FRONT, 3);
      send_item(K_CLEAR, '0);
   endtask

   task automatic test_full_with_backpressure();
      logic signed [DATA_W-1:0] pushed [DEPTH];
      req_idle_on = 1'b0;
      // The receiver holds off while the sender keeps offering items.
      hold_cycles = 250;
      for (int i = 0; i < DEPTH; i++) begin
         pushed[i] = $urandom;
         send_item((i % 2) ? K_PUSH_FRONT : K_PUSH_BACK, pushed[i]);
      end
      send_item(K_PUSH_FRONT, pick_value());
      send_item(K_PUSH_BACK, pick_value());
      send_item(K_LIST, '0);
      send_item(K_REMOVE, pushed[DEPTH - 2]);
      send_item(K_REMOVE, pushed[7]);
      send_item(K_PUSH_BACK, pick_value());
      wait_drained();
      req_idle_on = 1'b1;
      send_item(K_CLEAR, '0);
      send_item(K_LIST, '0);
   endtask

   task automatic test_random_mix();
      int bias [9] = '{62, 62, 40, 20, 62, 45, 20, 62, 30};
      for (int blk = 0; blk < 9; blk++) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         run_random(40, bias[blk]);
      end
   endtask

   task automatic test_steady_stream();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(50, 45);
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_checked++;
         if (pending_rsp.size() == 0) begin
            note_error($sformatf("unexpected result: status %0d value %0d count %0d last %0d",
                                 rsp_ch.status, rsp_ch.value_res, rsp_ch.count,
                                 rsp_ch.last));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.value_res !== want.value_res ||
                rsp_ch.count !== want.count || rsp_ch.last !== want.last) begin
               note_error($sformatf({"result mismatch: expected status %0d value %0d ",
                                     "count %0d last %0d, got status %0d value %0d ",
                                     "count %0d last %0d"},
                                    want.status, want.value_res, want.count, want.last,
                                    rsp_ch.status, rsp_ch.value_res, rsp_ch.count,
                                    rsp_ch.last));
            end
         end
      end
   end

   initial begin : watchdog
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : test_sequence
      req_ch.valid = 1'b0;
      req_ch.kind  = K_NONE;
      req_ch.value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_full_with_backpressure();
      test_random_mix();
      test_steady_stream();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display({"Covered: push %0d, pop %0d, remove %0d, list %0d, clear %0d, ",
                "no-op %0d items; %0d results checked."},
               kind_hits[K_PUSH_FRONT] + kind_hits[K_PUSH_BACK],
               kind_hits[K_POP_FRONT] + kind_hits[K_POP_BACK], kind_hits[K_REMOVE],
               kind_hits[K_LIST], kind_hits[K_CLEAR], kind_hits[K_NONE], results_checked);
      $display({"Pushes refused on a full deque: %0d, removes with no match: %0d, ",
                "mismatches: %0d."},
               full_rejects, not_found_hits, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/bdq_pkg.sv
rtl/bdq_ifs.sv
rtl/bdq_ram.sv
rtl/bdq_outreg.sv
rtl/bdq_seq.sv
rtl/bounded_deque_with_delete.sv
rtl/bdq_chk.sv
sim/tb.sv
